### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, disabled while rst is high
`define LRD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lrd assertion failed");

// concurrent check that also holds across reset
`define LRD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("lrd assertion failed");

`endif

### hdl/lrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrd_pkg;

   localparam int unsigned RING_DEPTH  = 256;
   localparam int unsigned RING_AW     = $clog2(RING_DEPTH);
   localparam int unsigned RING_START  = 239;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 32;
   localparam int unsigned BUF_W       = 20;
   localparam int unsigned CNT_W       = 5;
   localparam int unsigned RUN_W       = 5;
   localparam int unsigned LIT_BITS    = 9;
   localparam int unsigned MATCH_BITS  = 13;
   localparam int unsigned MIN_MATCH   = 2;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic              clear;
      logic              is_match;
      logic [BYTE_W-1:0] data;
      logic [RUN_W-1:0]  count;
      logic              last;
   } cmd_type;

endpackage

`default_nettype wire

### hdl/lrd_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module lrd_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lrd_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output lrd_pkg::cmd_type pop_data,
   output logic             empty
);
   import lrd_pkg::*;

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hdl/lrd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lrd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [lrd_pkg::BYTE_W-1:0]  req_in_byte,
   input  logic                        req_start_req,
   input  logic [lrd_pkg::LEN_W-1:0]   total_length,
   output logic                        cmd_push,
   output lrd_pkg::cmd_type            cmd_data,
   input  logic                        cmd_full
);
   import lrd_pkg::*;

   logic [BUF_W-1:0]  bits_ff, bits_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  prod_ff, prod_in;
   logic              fin_ff, fin_in;
   logic              clr_ff, clr_in;

   logic              accept;
   logic [BUF_W-1:0]  bits0, bits1, aligned, mask;
   logic [CNT_W-1:0]  cnt0, cnt1, cnt_new, shamt;
   logic [LEN_W-1:0]  prod0, remaining;
   logic              fin0, clr0, done;
   logic              flag, is_lit, is_match;
   logic [BYTE_W-1:0] field;
   logic [3:0]        len;
   logic [RUN_W-1:0]  mlen, run;
   logic              match_last, lit_last;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   always_comb begin
      bits0 = req_start_req ? '0 : bits_ff;
      cnt0  = req_start_req ? '0 : cnt_ff;
      prod0 = req_start_req ? '0 : prod_ff;
      fin0  = req_start_req ? 1'b0 : fin_ff;
      clr0  = req_start_req || clr_ff;
      done  = fin0 || (prod0 >= total_length);

      bits1   = {bits0[BUF_W-BYTE_W-1:0], req_in_byte};
      cnt1    = cnt0 + CNT_W'(BYTE_W);
      shamt   = CNT_W'(BUF_W) - cnt1;
      aligned = bits1 << shamt;
      flag    = aligned[BUF_W-1];
      field   = aligned[BUF_W-2 -: BYTE_W];
      len     = aligned[BUF_W-2-BYTE_W -: 4];

      is_lit   = flag && (cnt1 >= CNT_W'(LIT_BITS));
      is_match = !flag && (cnt1 >= CNT_W'(MATCH_BITS));

      remaining  = total_length - prod0;
      mlen       = RUN_W'(len) + RUN_W'(MIN_MATCH);
      match_last = (LEN_W'(mlen) >= remaining);
      lit_last   = (remaining == LEN_W'(1));
      run        = is_lit ? RUN_W'(1) : (match_last ? remaining[RUN_W-1:0] : mlen);

      if (is_lit) begin
         cnt_new = cnt1 - CNT_W'(LIT_BITS);
      end else if (is_match) begin
         cnt_new = cnt1 - CNT_W'(MATCH_BITS);
      end else begin
         cnt_new = cnt1;
      end
      mask = (BUF_W'(1) << cnt_new) - BUF_W'(1);

      cmd_push          = accept && !done && (is_lit || is_match);
      cmd_data.clear    = clr0;
      cmd_data.is_match = is_match;
      cmd_data.data     = field;
      cmd_data.count    = run;
      cmd_data.last     = is_lit ? lit_last : match_last;

      bits_in = bits_ff;
      cnt_in  = cnt_ff;
      prod_in = prod_ff;
      fin_in  = fin_ff;
      clr_in  = clr_ff;
      if (accept) begin
         if (done) begin
            bits_in = bits0;
            cnt_in  = cnt0;
            prod_in = prod0;
            fin_in  = 1'b1;
            clr_in  = clr0;
         end else begin
            bits_in = bits1 & mask;
            cnt_in  = cnt_new;
            prod_in = prod0;
            fin_in  = 1'b0;
            clr_in  = clr0;
            if (is_lit || is_match) begin
               prod_in = prod0 + LEN_W'(run);
               fin_in  = cmd_data.last;
               clr_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
         cnt_ff  <= '0;
         prod_ff <= '0;
         fin_ff  <= 1'b0;
         clr_ff  <= 1'b0;
      end else begin
         bits_ff <= bits_in;
         cnt_ff  <= cnt_in;
         prod_ff <= prod_in;
         fin_ff  <= fin_in;
         clr_ff  <= clr_in;
      end
   end

endmodule

`default_nettype wire

### hdl/lrd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lrd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  lrd_pkg::cmd_type            cmd_data,
   input  logic                        cmd_empty,
   output logic                        cmd_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [lrd_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_last_byte
);
   import lrd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [BYTE_W-1:0]     ring_mem [RING_DEPTH];

   logic [1:0]            state_ff, state_in;
   logic [RING_DEPTH-1:0] valid_ff, valid_in;
   logic [RING_AW-1:0]    wp_ff, wp_in;
   logic                  out_valid_ff, out_valid_in;
   logic [RING_AW-1:0]    addr_ff, addr_in;
   logic [RUN_W-1:0]      left_ff, left_in;
   logic                  match_ff, match_in;
   logic                  last_ff, last_in;
   logic [BYTE_W-1:0]     lit_ff, lit_in;
   logic [BYTE_W-1:0]     out_byte_ff, out_byte_in;
   logic                  out_last_ff, out_last_in;
   logic [BYTE_W-1:0]     rd_data_ff;
   logic                  rd_vld_ff;

   logic                  emit;
   logic [BYTE_W-1:0]     emit_byte;

   assign cmd_pop       = (state_ff == ST_IDLE) && !cmd_empty;
   assign emit          = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_pop);
   assign emit_byte     = match_ff ? (rd_vld_ff ? rd_data_ff : '0) : lit_ff;
   assign rsp_empty     = !out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_last_byte = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      wp_in        = wp_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      match_in     = match_ff;
      last_in      = last_ff;
      lit_in       = lit_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_pop;

      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               addr_in  = cmd_data.data;
               lit_in   = cmd_data.data;
               left_in  = cmd_data.count;
               match_in = cmd_data.is_match;
               last_in  = cmd_data.last;
               if (cmd_data.clear) begin
                  valid_in = '0;
                  wp_in    = RING_AW'(RING_START);
               end
               state_in = cmd_data.is_match ? ST_READ : ST_EMIT;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit) begin
               valid_in[wp_ff] = 1'b1;
               wp_in           = wp_ff + 1'b1;
               out_valid_in    = 1'b1;
               out_byte_in     = emit_byte;
               out_last_in     = last_ff && (left_ff == RUN_W'(1));
               addr_in         = addr_ff + 1'b1;
               left_in         = left_ff - 1'b1;
               state_in        = (left_ff == RUN_W'(1)) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         wp_ff        <= RING_AW'(RING_START);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         wp_ff        <= wp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      left_ff     <= left_in;
      match_ff    <= match_in;
      last_ff     <= last_in;
      lit_ff      <= lit_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         ring_mem[wp_ff] <= emit_byte;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= ring_mem[addr_ff];
         rd_vld_ff  <= valid_ff[addr_ff];
      end
   end

endmodule

`default_nettype wire

### hdl/lzss_ring_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// LZSS decoder with a 256-byte history ring (8-bit position, 4-bit length, copy of
// length+2 bytes, ring write pointer starting at 239). Compressed bytes are pushed
// one per item; the front decodes the bit stream and accepts one item per cycle
// while its 4-entry command queue has room. The back takes a command in ST_IDLE,
// then emits a literal from ST_EMIT and each copied byte through ST_READ (registered
// ring read) and then ST_EMIT (ring write and output); ST_EMIT stalls while the
// result register holds an unpopped byte, and a byte waits there until popped. Output
// stops at total_length and that byte carries rsp_last_byte. A start flag clears the
// decoder; the ring reads as zero through per-entry valid bits, so there is no
// clearing pass. csr_total_length may be written only while idle.

module lzss_ring_decoder_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [lrd_pkg::BYTE_W-1:0]  req_in_byte,
   input  logic                        req_start_req,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [lrd_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_last_byte,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lrd_pkg::LEN_W-1:0]   csr_total_length
);
   import lrd_pkg::*;

   logic [LEN_W-1:0] total_length_ff, total_length_in;
   cmd_type          push_cmd, pop_cmd;
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;

   assign csr_ready       = 1'b1;
   assign total_length_in = (csr_valid && csr_ready) ? csr_total_length : total_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_length_ff <= '0;
      end else begin
         total_length_ff <= total_length_in;
      end
   end

   lrd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_in_byte   (req_in_byte),
      .req_start_req (req_start_req),
      .total_length  (total_length_ff),
      .cmd_push      (cmd_push),
      .cmd_data      (push_cmd),
      .cmd_full      (cmd_full)
   );

   lrd_cmd_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (pop_cmd),
      .empty     (cmd_empty)
   );

   lrd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_data      (pop_cmd),
      .cmd_empty     (cmd_empty),
      .cmd_pop       (cmd_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

`default_nettype wire

### hdl/lrd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lrd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_full,
   input logic                        rsp_empty,
   input logic                        rsp_pop,
   input logic [lrd_pkg::BYTE_W-1:0]  rsp_out_byte,
   input logic                        rsp_last_byte,
   input logic                        csr_ready
);

   // config port never back-pressures
   `LRD_ASSERT(a_csr_ready, clock, reset, csr_ready)

   // a waiting result holds until popped
   `LRD_ASSERT(a_rsp_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> !rsp_empty)
   `LRD_ASSERT(a_byte_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> $stable(rsp_out_byte))
   `LRD_ASSERT(a_last_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> $stable(rsp_last_byte))

   // reset leaves no result and an open input
   `LRD_ASSERT_ALWAYS(a_reset_clean, clock, reset |=> (rsp_empty && !req_full))

endmodule

bind lzss_ring_decoder_core lrd_checker u_checker (.*);

`default_nettype wire

### test/lzss_ring_decoder_core_test.sv
`timescale 1ns / 1ps

module lzss_ring_decoder_core_test;
   import lrd_pkg::*;

   localparam int ITEM_TARGET   = 350;
   localparam int SETTLE_CYCLES = 100;
   localparam int TAIL_CYCLES   = 100;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int MAX_RUN       = 17;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } decoded_type;

   typedef enum logic [1:0] {BY_MODEL, NO_RESULT, ONE_RESULT} row_check_type;
   typedef enum logic {ROW_ITEM, ROW_LENGTH} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] data;
      logic              start;
      row_check_type     check;
      logic [BYTE_W-1:0] t_data;
      logic              t_last;
   } step_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   logic [BYTE_W-1:0] req_in_byte = '0;
   logic              req_start_req = 1'b0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_last_byte;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [LEN_W-1:0]  csr_total_length = '0;

   lzss_ring_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_in_byte      (req_in_byte),
      .req_start_req    (req_start_req),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_byte    (rsp_last_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_total_length (csr_total_length)
   );

   // decoder state mirror
   logic [BYTE_W-1:0]  hist [RING_DEPTH];
   logic [RING_AW-1:0] wr_ptr;
   logic [BUF_W-1:0]   bitbuf;
   int unsigned        nbits;
   logic [LEN_W-1:0]   produced;
   logic [LEN_W-1:0]   length_reg;
   bit                 done;
   decoded_type        run_out [MAX_RUN];
   int                 run_n;

   decoded_type       decoded_q [$];
   logic [BYTE_W-1:0] file_bytes [$];
   int                errors = 0;
   int                sent_items = 0;
   int                burst_left = 0;
   int                cycle_count = 0;

   step_row_type script [21] = '{
      '{ROW_LENGTH, 32'hFFFF_FFFF, 8'h00, 1'b0, NO_RESULT, 8'h00, 1'b0},
      '{ROW_ITEM, 32'h0, 8'hFF, 1'b1, NO_RESULT, 8'h00, 1'b0},
      '{ROW_ITEM, 32'h0, 8'hC0, 1'b0, ONE_RESULT, 8'hFF, 1'b0},
      '{ROW_ITEM, 32'h0, 8'h1D, 1'b0, ONE_RESULT, 8'h00, 1'b0},
      '{ROW_ITEM, 32'h0, 8'hFE, 1'b0, BY_MODEL, 8'h00, 1'b0},
      '{ROW_ITEM, 32'h0, 8'h00, 1'b0, NO_RESULT, 8'h00, 1'b0},
      '{ROW_ITEM, 32'h0, 8'h0D, 1'b0, BY_MODEL, 8'h00, 1'b0},
      '{ROW_ITEM, 32'h0, 8'h2F, 1'b0, ONE_RESULT, 8'hA5, 1'b0},
      '{ROW_LENGTH, 32'h1, 8'h00, 1'b0, NO_RESULT, 8'h00, 1'b0},
      '{ROW_ITEM, 32'h0, 8'hAD, 1'b1, NO_RESULT, 8'h00, 1'b0},
      '{ROW_ITEM, 32'h0, 8'h00, 1'b0, ONE_RESULT, 8'h5A, 1'b1},
      '{ROW_ITEM, 32'h0, 8'hFF, 1'b0, NO_RESULT, 8'h00, 1'b0},
      '{ROW_ITEM, 32'h0, 8'hAD, 1'b1, NO_RESULT, 8'h00, 1'b0},
      '{ROW_ITEM, 32'h0, 8'h80, 1'b0, ONE_RESULT, 8'h5B, 1'b1},
      '{ROW_LENGTH, 32'h0, 8'h00, 1'b0, NO_RESULT, 8'h00, 1'b0},
      '{ROW_ITEM, 32'h0, 8'hFF, 1'b1, NO_RESULT, 8'h00, 1'b0},
      '{ROW_ITEM, 32'h0, 8'h00, 1'b0, NO_RESULT, 8'h00, 1'b0},
      '{ROW_LENGTH, 32'h5, 8'h00, 1'b0, NO_RESULT, 8'h00, 1'b0},
      '{ROW_ITEM, 32'h0, 8'h9E, 1'b1, NO_RESULT, 8'h00, 1'b0},
      '{ROW_ITEM, 32'h0, 8'h3B, 1'b0, ONE_RESULT, 8'h3C, 1'b0},
      '{ROW_ITEM, 32'h0, 8'hFF, 1'b0, BY_MODEL, 8'h00, 1'b0}
   };

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("error at cycle %0d: %s", cycle_count, msg);
      errors++;
   endtask

   task automatic clear_history();
      for (int i = 0; i < RING_DEPTH; i++) hist[i] = '0;
      wr_ptr = RING_AW'(RING_START);
      bitbuf = '0;
      nbits = 0;
      produced = '0;
      done = 1'b0;
   endtask

   function automatic bit put_byte(input logic [BYTE_W-1:0] v);
      bit last;
      hist[wr_ptr] = v;
      wr_ptr = wr_ptr + 1'b1;
      produced = produced + 1'b1;
      last = (produced >= length_reg);
      run_out[run_n] = '{data: v, last: last};
      run_n++;
      if (last) done = 1'b1;
      return last;
   endfunction

   task automatic lzss_unpack(input logic [BYTE_W-1:0] b, input logic st);
      logic              flag;
      logic [BYTE_W-1:0] pos;
      logic [3:0]        run;
      run_n = 0;
      if (st) clear_history();
      if (done || produced >= length_reg) begin
         done = 1'b1;
         return;
      end
      bitbuf = {bitbuf[BUF_W-9:0], b};
      nbits += 8;
      flag = bitbuf[nbits-1];
      if (flag && nbits >= LIT_BITS) begin
         nbits -= LIT_BITS;
         void'(put_byte(BYTE_W'(bitbuf >> nbits)));
      end else if (!flag && nbits >= MATCH_BITS) begin
         pos = BYTE_W'(bitbuf >> (nbits - LIT_BITS));
         run = 4'(bitbuf >> (nbits - MATCH_BITS));
         nbits -= MATCH_BITS;
         for (int c = 0; c < run + MIN_MATCH; c++) begin
            if (put_byte(hist[RING_AW'(pos + c)])) break;
         end
      end
      bitbuf = bitbuf & ((BUF_W'(1) << nbits) - 1'b1);
   endtask

   task automatic idle_cycles(input int n);
      @(negedge clock);
      req_push <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_item(input logic [BYTE_W-1:0] b, input logic st, input row_check_type chk,
                            input logic [BYTE_W-1:0] tb, input logic tl);
      @(negedge clock);
      req_push <= 1'b1;
      req_in_byte <= b;
      req_start_req <= st;
      @(posedge clock);
      while (req_full) @(posedge clock);
      lzss_unpack(b, st);
      sent_items++;
      case (chk)
         BY_MODEL: begin
            for (int i = 0; i < run_n; i++) decoded_q.push_back(run_out[i]);
         end
         ONE_RESULT: decoded_q.push_back('{data: tb, last: tl});
         default: ;
      endcase
      if (burst_left == 0) begin
         idle_cycles($urandom_range(1, 12));
         burst_left = $urandom_range(1, 40);
      end else begin
         burst_left--;
      end
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_push <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] v);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_total_length <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      length_reg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random well-formed token stream, padded to a byte boundary
   task automatic build_stream(input int n_tokens);
      bit                bits_q [$];
      logic [BYTE_W-1:0] v;
      logic [BYTE_W-1:0] pos;
      logic [3:0]        run;
      file_bytes.delete();
      for (int t = 0; t < n_tokens; t++) begin
         if ($urandom_range(0, 1) == 1) begin
            v = BYTE_W'($urandom);
            bits_q.push_back(1'b1);
            for (int k = 7; k >= 0; k--) bits_q.push_back(v[k]);
         end else begin
            if ($urandom_range(0, 3) == 0) pos = BYTE_W'($urandom);
            else pos = wr_ptr - BYTE_W'($urandom_range(1, 24));
            run = 4'($urandom);
            bits_q.push_back(1'b0);
            for (int k = 7; k >= 0; k--) bits_q.push_back(pos[k]);
            for (int k = 3; k >= 0; k--) bits_q.push_back(run[k]);
         end
      end
      while (bits_q.size() % 8 != 0) bits_q.push_back(1'($urandom_range(0, 1)));
      for (int i = 0; i < bits_q.size(); i += 8) begin
         for (int k = 0; k < 8; k++) v[7-k] = bits_q[i+k];
         file_bytes.push_back(v);
      end
   endtask

   // receiver stall pattern
   int pop_mode = 0;
   int mode_left = 0;
   int stall_left = 0;

   always @(negedge clock) begin
      logic p;
      if (mode_left == 0) begin
         pop_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      if (stall_left > 0) begin
         stall_left--;
         p = 1'b0;
      end else if (pop_mode == 0) begin
         p = 1'b1;
      end else if (pop_mode == 1) begin
         p = 1'($urandom_range(0, 1));
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 20);
         p = 1'b0;
      end else begin
         p = 1'b1;
      end
      rsp_pop <= p;
   end

   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %h last %b", rsp_out_byte, rsp_last_byte));
         end else begin
            want = decoded_q.pop_front();
            if (rsp_out_byte !== want.data)
               report_mismatch($sformatf("out_byte %h, expected %h", rsp_out_byte, want.data));
            if (rsp_last_byte !== want.last)
               report_mismatch($sformatf("last_byte %b, expected %b", rsp_last_byte, want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lzss_ring_decoder_core: mismatch");
         $finish;
      end
   end

   initial begin
      int   phase;
      int   pick;
      bit   fresh;
      bit   pause;
      logic st;
      length_reg = '0;
      clear_history();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_LENGTH) write_length(script[i].length);
         else send_item(script[i].data, script[i].start, script[i].check,
                        script[i].t_data, script[i].t_last);
      end

      phase = 0;
      while (sent_items < ITEM_TARGET) begin
         pick = $urandom_range(0, 15);
         if ($urandom_range(0, 5) != 0) begin
            case (pick)
               0: write_length('0);
               1: write_length(1);
               2: write_length(32'hFFFF_FFFF);
               3: write_length($urandom);
               default: write_length($urandom_range(2, 90));
            endcase
         end
         fresh = ($urandom_range(0, 4) != 0);
         pause = (phase == 2) || ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            // noise
            repeat ($urandom_range(1, 12)) begin
               st = ($urandom_range(0, 3) == 0);
               send_item(BYTE_W'($urandom), st, BY_MODEL, '0, 1'b0);
            end
         end else begin
            build_stream($urandom_range(3, 20));
            // broken stream: cut short
            if (pick == 1) begin
               while (file_bytes.size() > 1 && $urandom_range(0, 3) != 0)
                  void'(file_bytes.pop_back());
            end
            foreach (file_bytes[i]) begin
               if (pause && i == file_bytes.size() / 2) hold_until_drained();
               send_item(file_bytes[i], fresh && i == 0, BY_MODEL, '0, 1'b0);
            end
         end
         phase++;
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("lzss_ring_decoder_core: match");
      end else begin
         $display("lzss_ring_decoder_core: mismatch");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/lrd_pkg.sv
hdl/lrd_cmd_fifo.sv
hdl/lrd_front.sv
hdl/lrd_back.sv
hdl/lzss_ring_decoder_core.sv
hdl/lrd_checker.sv
test/lzss_ring_decoder_core_test.sv
